/* rtl/lsp_pkg.sv */
`timescale 1ns / 1ps
package lsp_pkg;

   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 128;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;

   localparam int REQ_W = 96;
   localparam int RSP_W = 80;
   localparam int COL_W = 11;
   localparam int ROW_W = 7;

   localparam int SQ_IN_W  = 64;
   localparam int SQ_OUT_W = 32;
   localparam int SQ_LAT   = SQ_OUT_W + 2;

   localparam int CR_W   = 36;
   localparam int ACC_W  = 34;
   localparam int ANG_W  = 17;
   localparam int CR_LAT = CORDIC_STAGES + 2;

   localparam int DIV_N_W = 26;
   localparam int DIV_D_W = 17;
   localparam int DIV_QW  = $clog2(MAX_HEIGHT);
   localparam int DV_LAT  = DIV_QW + 1;

   typedef struct packed {
      logic [11:0] col_count;
      logic [7:0]  row_count;
      logic [14:0] fov_up_angle;
      logic [14:0] fov_down_angle;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{12'd1024, 8'd64, 15'd546, 15'd4551};

   typedef enum logic [1:0] {
      REG_WIDTH    = 2'd0,
      REG_HEIGHT   = 2'd1,
      REG_FOV_UP   = 2'd2,
      REG_FOV_DOWN = 2'd3
   } reg_index_type;

   function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
      logic signed [ACC_W-1:0] v;
      unique case (i)
         0:  v = 34'sh020000000;
         1:  v = 34'sh012E4051E;
         2:  v = 34'sh009FB385B;
         3:  v = 34'sh0051111D4;
         4:  v = 34'sh0028B0D43;
         5:  v = 34'sh00145D7E1;
         6:  v = 34'sh000A2F61E;
         7:  v = 34'sh000517C55;
         8:  v = 34'sh00028BE53;
         9:  v = 34'sh000145F2F;
         10: v = 34'sh0000A2F98;
         11: v = 34'sh0000517CC;
         12: v = 34'sh000028BE6;
         13: v = 34'sh0000145F3;
         14: v = 34'sh00000A2FA;
         15: v = 34'sh00000517D;
         16: v = 34'sh0000028BE;
         17: v = 34'sh00000145F;
         18: v = 34'sh000000A30;
         19: v = 34'sh000000518;
         20: v = 34'sh00000028C;
         21: v = 34'sh000000146;
         22: v = 34'sh0000000A3;
         23: v = 34'sh000000051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/lsp_csr.sv */
`timescale 1ns / 1ps
module lsp_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output lsp_pkg::cfg_type cfg
);
   import lsp_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type sel;
   logic          wr;

   assign sel = reg_index_type'(csr_paddr[3:2]);
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (sel)
            REG_WIDTH:    cfg_in.col_count      = csr_pwdata[11:0];
            REG_HEIGHT:   cfg_in.row_count      = csr_pwdata[7:0];
            REG_FOV_UP:   cfg_in.fov_up_angle   = csr_pwdata[14:0];
            REG_FOV_DOWN: cfg_in.fov_down_angle = csr_pwdata[14:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (sel)
         REG_WIDTH:    csr_prdata = 32'(cfg_ff.col_count);
         REG_HEIGHT:   csr_prdata = 32'(cfg_ff.row_count);
         REG_FOV_UP:   csr_prdata = 32'(cfg_ff.fov_up_angle);
         REG_FOV_DOWN: csr_prdata = 32'(cfg_ff.fov_down_angle);
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

/* rtl/lsp_sqrt.sv */
`timescale 1ns / 1ps
module lsp_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [lsp_pkg::SQ_IN_W-1:0]  n,
   output logic [lsp_pkg::SQ_OUT_W-1:0] root
);
   import lsp_pkg::*;

   logic [SQ_IN_W-1:0]  rem_ff [SQ_OUT_W+1];
   logic [SQ_IN_W-1:0]  rem_in [SQ_OUT_W+1];
   logic [SQ_IN_W-1:0]  res_ff [SQ_OUT_W+1];
   logic [SQ_IN_W-1:0]  res_in [SQ_OUT_W+1];
   logic [SQ_OUT_W-1:0] root_ff, root_in;

   // one result bit per stage
   always_comb begin
      logic [SQ_IN_W-1:0] bt, tr;
      rem_in[0] = n;
      res_in[0] = '0;
      for (int k = 1; k <= SQ_OUT_W; k++) begin
         bt = SQ_IN_W'(1) << (SQ_IN_W - 2 * k);
         tr = res_ff[k-1] + bt;
         if (rem_ff[k-1] >= tr) begin
            rem_in[k] = rem_ff[k-1] - tr;
            res_in[k] = (res_ff[k-1] >> 1) + bt;
         end else begin
            rem_in[k] = rem_ff[k-1];
            res_in[k] = res_ff[k-1] >> 1;
         end
      end
   end

   // round to nearest
   always_comb begin
      if (rem_ff[SQ_OUT_W] > res_ff[SQ_OUT_W]) begin
         root_in = SQ_OUT_W'(res_ff[SQ_OUT_W] + SQ_IN_W'(1));
      end else begin
         root_in = SQ_OUT_W'(res_ff[SQ_OUT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= SQ_OUT_W; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

/* rtl/lsp_cordic.sv */
`timescale 1ns / 1ps
module lsp_cordic (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [lsp_pkg::CR_W-1:0]  vec_x,
   input  logic signed [lsp_pkg::CR_W-1:0]  vec_y,
   output logic signed [lsp_pkg::ANG_W-1:0] angle
);
   import lsp_pkg::*;

   localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'sd2147483648);

   logic signed [CR_W-1:0]  x_ff   [CORDIC_STAGES+1];
   logic signed [CR_W-1:0]  x_in   [CORDIC_STAGES+1];
   logic signed [CR_W-1:0]  y_ff   [CORDIC_STAGES+1];
   logic signed [CR_W-1:0]  y_in   [CORDIC_STAGES+1];
   logic signed [ACC_W-1:0] acc_ff [CORDIC_STAGES+1];
   logic signed [ACC_W-1:0] acc_in [CORDIC_STAGES+1];
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic [ACC_W-1:0]        mag, rnd;

   always_comb begin
      // left half plane: mirror and start from plus or minus pi
      if (vec_x[CR_W-1]) begin
         x_in[0]   = -vec_x;
         y_in[0]   = -vec_y;
         acc_in[0] = vec_y[CR_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         x_in[0]   = vec_x;
         y_in[0]   = vec_y;
         acc_in[0] = '0;
      end
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
         if (!y_ff[k-1][CR_W-1]) begin
            x_in[k]   = x_ff[k-1] + (y_ff[k-1] >>> (k - 1));
            y_in[k]   = y_ff[k-1] - (x_ff[k-1] >>> (k - 1));
            acc_in[k] = acc_ff[k-1] + atan_entry(k - 1);
         end else begin
            x_in[k]   = x_ff[k-1] - (y_ff[k-1] >>> (k - 1));
            y_in[k]   = y_ff[k-1] + (x_ff[k-1] >>> (k - 1));
            acc_in[k] = acc_ff[k-1] - atan_entry(k - 1);
         end
      end
   end

   // round half away from zero to a 16-bit binary angle
   always_comb begin
      mag    = acc_ff[CORDIC_STAGES][ACC_W-1] ? ACC_W'(-acc_ff[CORDIC_STAGES])
                                              : ACC_W'(acc_ff[CORDIC_STAGES]);
      rnd    = (mag + ACC_W'(32768)) >> 16;
      ang_in = acc_ff[CORDIC_STAGES][ACC_W-1] ? ANG_W'(-rnd) : ANG_W'(rnd);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CORDIC_STAGES; k++) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            acc_ff[k] <= acc_in[k];
         end
         ang_ff <= ang_in;
      end
   end

   assign angle = ang_ff;

endmodule

/* rtl/lsp_rowdiv.sv */
`timescale 1ns / 1ps
module lsp_rowdiv (
   input  logic                        clock,
   input  logic                        en,
   input  logic [lsp_pkg::DIV_N_W-1:0] num,
   input  logic [lsp_pkg::DIV_D_W-1:0] den,
   output logic [lsp_pkg::DIV_QW-1:0]  quot
);
   import lsp_pkg::*;

   localparam int CMP_W = DIV_N_W + DIV_QW;

   logic [CMP_W-1:0]   rem_ff [DIV_QW+1];
   logic [CMP_W-1:0]   rem_in [DIV_QW+1];
   logic [DIV_D_W-1:0] den_ff [DIV_QW+1];
   logic [DIV_D_W-1:0] den_in [DIV_QW+1];
   logic [DIV_QW-1:0]  q_ff   [DIV_QW+1];
   logic [DIV_QW-1:0]  q_in   [DIV_QW+1];
   logic               ovf_ff [DIV_QW+1];
   logic               ovf_in [DIV_QW+1];

   // restoring division, one quotient bit per stage, saturating
   always_comb begin
      logic [CMP_W-1:0] t;
      rem_in[0] = CMP_W'(num);
      den_in[0] = den;
      q_in[0]   = '0;
      ovf_in[0] = CMP_W'(num) >= (CMP_W'(den) << DIV_QW);
      for (int k = 1; k <= DIV_QW; k++) begin
         t         = CMP_W'(den_ff[k-1]) << (DIV_QW - k);
         den_in[k] = den_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         q_in[k]   = q_ff[k-1];
         if (rem_ff[k-1] >= t) begin
            rem_in[k]             = rem_ff[k-1] - t;
            q_in[k][DIV_QW - k]   = 1'b1;
         end else begin
            rem_in[k] = rem_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_QW; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   assign quot = ovf_ff[DIV_QW] ? '1 : q_ff[DIV_QW];

endmodule

/* rtl/lidar_spherical_projection.sv */
// throughput: one point per cycle while the output buffer is not full, set by the
// pipelined square roots, CORDIC and row divider
// the whole pipeline holds while the two-entry output buffer is full
// reset: synchronous, active high; clears valid bits and restores register defaults
`timescale 1ns / 1ps
module lidar_spherical_projection (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // point_x, point_y, point_z, point_index, zero fill
   input  logic [lsp_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // pixel_col, pixel_row, range_mm, pitch_angle, index_out, zero fill
   output logic [lsp_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [3:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import lsp_pkg::*;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [19:0]        idx;
   } point_type;

   typedef struct packed {
      logic [47:0] xx;
      logic [47:0] yy;
      logic [47:0] zz;
      point_type   pt;
      logic        yaw_zero;
   } sq_type;

   typedef struct packed {
      logic [47:0] hsq;
      logic [47:0] rsq;
      point_type   pt;
      logic        yaw_zero;
   } sum_type;

   typedef struct packed {
      point_type pt;
      logic      yaw_zero;
   } side_a_type;

   typedef struct packed {
      logic [19:0] idx;
      logic [23:0] range;
      logic        yaw_zero;
      logic        pitch_zero;
   } side_b_type;

   typedef struct packed {
      logic signed [16:0] yaw;
      logic signed [15:0] pitch;
      logic [23:0]        range;
      logic [19:0]        idx;
   } p1_type;

   typedef struct packed {
      logic [28:0]        colprod;
      logic signed [26:0] num;
      logic [15:0]        sum;
      logic signed [15:0] pitch;
      logic [23:0]        range;
      logic [19:0]        idx;
   } p2_type;

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic signed [15:0] pitch;
      logic [23:0]        range;
      logic [19:0]        idx;
      logic               row_zero;
      logic [ROW_W-1:0]   hcap;
   } side_c_type;

   typedef struct packed {
      logic [19:0]        index_out;
      logic signed [15:0] pitch_angle;
      logic [23:0]        range_mm;
      logic [ROW_W-1:0]   pixel_row;
      logic [COL_W-1:0]   pixel_col;
   } rsp_type;

   cfg_type cfg;

   logic en;

   point_type  s1_ff, s1_in;
   sq_type     s2_ff, s2_in;
   sum_type    s3_ff, s3_in;
   logic       s1_v_ff, s2_v_ff, s3_v_ff;
   side_a_type a_ff [SQ_LAT];
   logic       a_v_ff [SQ_LAT];
   side_b_type b_ff [CR_LAT];
   logic       b_v_ff [CR_LAT];
   p1_type     p1_ff, p1_in;
   p2_type     p2_ff, p2_in;
   side_c_type p3_ff, p3_in;
   logic       p1_v_ff, p2_v_ff, p3_v_ff;
   logic [DIV_N_W-1:0] dn_ff, dn_in;
   logic [DIV_D_W-1:0] dd_ff, dd_in;
   side_c_type c_ff [DV_LAT];
   logic       c_v_ff [DV_LAT];

   logic [SQ_OUT_W-1:0]    range_root, rho_root;
   logic signed [CR_W-1:0] yaw_x, yaw_y, pitch_x, pitch_y;
   logic signed [ANG_W-1:0] yaw_ang, pitch_ang;
   logic [DIV_QW-1:0]      row_q;

   rsp_type fin, out_ff, skid_ff;
   logic    out_v_ff, skid_v_ff;

   lsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en         = !skid_v_ff;
   assign req_tready = en;

   // input, squares and sums
   always_comb begin
      s1_in.x   = req_tdata[23:0];
      s1_in.y   = req_tdata[47:24];
      s1_in.z   = req_tdata[71:48];
      s1_in.idx = req_tdata[91:72];

      s2_in.xx       = 48'(s1_ff.x * s1_ff.x);
      s2_in.yy       = 48'(s1_ff.y * s1_ff.y);
      s2_in.zz       = 48'(s1_ff.z * s1_ff.z);
      s2_in.pt       = s1_ff;
      s2_in.yaw_zero = (s1_ff.x == '0) && (s1_ff.y == '0);

      s3_in.hsq      = s2_ff.xx + s2_ff.yy;
      s3_in.rsq      = s2_ff.xx + s2_ff.yy + s2_ff.zz;
      s3_in.pt       = s2_ff.pt;
      s3_in.yaw_zero = s2_ff.yaw_zero;
   end

   lsp_sqrt u_range_sqrt (
      .clock (clock),
      .en    (en),
      .n     (SQ_IN_W'(s3_ff.rsq)),
      .root  (range_root)
   );

   lsp_sqrt u_rho_sqrt (
      .clock (clock),
      .en    (en),
      .n     ({s3_ff.hsq, 16'h0000}),
      .root  (rho_root)
   );

   assign yaw_x   = CR_W'(signed'({a_ff[SQ_LAT-1].pt.x, 8'h00}));
   assign yaw_y   = CR_W'(signed'({a_ff[SQ_LAT-1].pt.y, 8'h00}));
   assign pitch_x = signed'(CR_W'(rho_root));
   assign pitch_y = CR_W'(signed'({a_ff[SQ_LAT-1].pt.z, 8'h00}));

   lsp_cordic u_yaw_cordic (
      .clock (clock),
      .en    (en),
      .vec_x (yaw_x),
      .vec_y (yaw_y),
      .angle (yaw_ang)
   );

   lsp_cordic u_pitch_cordic (
      .clock (clock),
      .en    (en),
      .vec_x (pitch_x),
      .vec_y (pitch_y),
      .angle (pitch_ang)
   );

   // clamp, scale, divider setup
   always_comb begin
      logic signed [16:0] pc;
      logic [16:0]        yaw_off;
      logic signed [17:0] diff;
      logic [13:0]        colr;
      logic [11:0]        wcap;
      logic [7:0]         hm1;

      if (b_ff[CR_LAT-1].yaw_zero) begin
         p1_in.yaw = '0;
      end else if (yaw_ang < -17'sd32768) begin
         p1_in.yaw = -17'sd32768;
      end else if (yaw_ang > 17'sd32768) begin
         p1_in.yaw = 17'sd32768;
      end else begin
         p1_in.yaw = yaw_ang;
      end
      if (b_ff[CR_LAT-1].pitch_zero) begin
         pc = '0;
      end else if (pitch_ang < -17'sd16384) begin
         pc = -17'sd16384;
      end else if (pitch_ang > 17'sd16384) begin
         pc = 17'sd16384;
      end else begin
         pc = pitch_ang;
      end
      p1_in.pitch = 16'(pc);
      p1_in.range = b_ff[CR_LAT-1].range;
      p1_in.idx   = b_ff[CR_LAT-1].idx;

      yaw_off       = 17'(p1_ff.yaw) + 17'd32768;
      p2_in.colprod = 29'(cfg.col_count * yaw_off);
      diff          = signed'({3'b000, cfg.fov_up_angle}) - 18'(p1_ff.pitch);
      p2_in.num     = 27'(diff * signed'({1'b0, cfg.row_count}));
      p2_in.sum     = 16'(cfg.fov_up_angle) + 16'(cfg.fov_down_angle);
      p2_in.pitch   = p1_ff.pitch;
      p2_in.range   = p1_ff.range;
      p2_in.idx     = p1_ff.idx;

      colr = 14'((30'(p2_ff.colprod) + 30'd32768) >> 16);
      wcap = (cfg.col_count == '0) ? '0 : cfg.col_count - 12'd1;
      if (wcap > 12'(MAX_WIDTH - 1)) begin
         wcap = 12'(MAX_WIDTH - 1);
      end
      p3_in.col = (colr > 14'(wcap)) ? COL_W'(wcap) : COL_W'(colr);
      hm1 = (cfg.row_count == '0) ? '0 : cfg.row_count - 8'd1;
      p3_in.hcap = (hm1 > 8'(MAX_HEIGHT - 1)) ? ROW_W'(MAX_HEIGHT - 1) : ROW_W'(hm1);
      p3_in.row_zero = (p2_ff.sum == '0) || p2_ff.num[26] || (p2_ff.num == '0);
      p3_in.pitch    = p2_ff.pitch;
      p3_in.range    = p2_ff.range;
      p3_in.idx      = p2_ff.idx;
      dn_in = DIV_N_W'({p2_ff.num, 1'b0}) + DIV_N_W'(p2_ff.sum);
      dd_in = {p2_ff.sum, 1'b0};
   end

   lsp_rowdiv u_rowdiv (
      .clock (clock),
      .en    (en),
      .num   (dn_ff),
      .den   (dd_ff),
      .quot  (row_q)
   );

   always_comb begin
      fin.pixel_col   = c_ff[DV_LAT-1].col;
      fin.range_mm    = c_ff[DV_LAT-1].range;
      fin.pitch_angle = c_ff[DV_LAT-1].pitch;
      fin.index_out   = c_ff[DV_LAT-1].idx;
      if (c_ff[DV_LAT-1].row_zero) begin
         fin.pixel_row = '0;
      end else if (ROW_W'(row_q) > c_ff[DV_LAT-1].hcap) begin
         fin.pixel_row = c_ff[DV_LAT-1].hcap;
      end else begin
         fin.pixel_row = ROW_W'(row_q);
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         a_ff[0] <= '{s3_ff.pt, s3_ff.yaw_zero};
         for (int i = 1; i < SQ_LAT; i++) begin
            a_ff[i] <= a_ff[i-1];
         end
         b_ff[0] <= '{a_ff[SQ_LAT-1].pt.idx, range_root[23:0],
                      a_ff[SQ_LAT-1].yaw_zero, range_root == '0};
         for (int i = 1; i < CR_LAT; i++) begin
            b_ff[i] <= b_ff[i-1];
         end
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         dn_ff <= dn_in;
         dd_ff <= dd_in;
         c_ff[0] <= p3_ff;
         for (int i = 1; i < DV_LAT; i++) begin
            c_ff[i] <= c_ff[i-1];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         for (int i = 0; i < SQ_LAT; i++) begin
            a_v_ff[i] <= 1'b0;
         end
         for (int i = 0; i < CR_LAT; i++) begin
            b_v_ff[i] <= 1'b0;
         end
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         for (int i = 0; i < DV_LAT; i++) begin
            c_v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         s1_v_ff   <= req_tvalid;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         a_v_ff[0] <= s3_v_ff;
         for (int i = 1; i < SQ_LAT; i++) begin
            a_v_ff[i] <= a_v_ff[i-1];
         end
         b_v_ff[0] <= a_v_ff[SQ_LAT-1];
         for (int i = 1; i < CR_LAT; i++) begin
            b_v_ff[i] <= b_v_ff[i-1];
         end
         p1_v_ff   <= b_v_ff[CR_LAT-1];
         p2_v_ff   <= p1_v_ff;
         p3_v_ff   <= p2_v_ff;
         c_v_ff[0] <= p3_v_ff;
         for (int i = 1; i < DV_LAT; i++) begin
            c_v_ff[i] <= c_v_ff[i-1];
         end
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_ff <= skid_ff;
         end else begin
            out_ff <= fin;
         end
      end else if (en && c_v_ff[DV_LAT-1]) begin
         skid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff  <= skid_v_ff || (en && c_v_ff[DV_LAT-1]);
         skid_v_ff <= 1'b0;
      end else if (en && c_v_ff[DV_LAT-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_W'(out_ff);

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without an output transfer pending");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready && skid_v_ff) |=> skid_v_ff)
      else $error("skid entry dropped while output stalled");

   a_pitch_bounds: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_ff.pitch_angle >= -16'sd16384 && out_ff.pitch_angle <= 16'sd16384))
      else $error("pitch outside quarter turn");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import lsp_pkg::*;

   localparam longint HALF_TURN = 64'sd2147483648;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [3:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   typedef struct packed {
      logic [10:0] col;
      logic [6:0]  row;
      logic [23:0] range_mm;
      logic [15:0] pitch;
      logic [19:0] index;
   } pixel_type;

   lidar_spherical_projection u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint isqrt_round(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      if (n > res) res = res + 1;
      return longint'(res);
   endfunction

   function automatic longint binary_angle(longint x, longint y);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      if (x < 0) begin
         acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (y >= 0) begin
            x = x + dx; y = y - dy; acc = acc + longint'(atan_entry(i));
         end else begin
            x = x - dx; y = y + dy; acc = acc - longint'(atan_entry(i));
         end
      end
      if (acc >= 0) return (acc + 32768) >>> 16;
      return -(((-acc) + 32768) >>> 16);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   class pixel_scoreboard;
      cfg_type   cfg;
      pixel_type pending[$];
      int        errors;

      function new();
         cfg = CFG_RESET;
         errors = 0;
      endfunction

      function void note_point(logic [REQ_W-1:0] d);
         longint x, y, z, hsq, rng, yaw, pitch, col, row, w, h, fu, fd, sum, num;
         pixel_type p;
         x = longint'($signed(d[23:0]));
         y = longint'($signed(d[47:24]));
         z = longint'($signed(d[71:48]));
         hsq = x * x + y * y;
         rng = isqrt_round(hsq + z * z);
         w = cfg.col_count;
         h = cfg.row_count;
         fu = cfg.fov_up_angle;
         fd = cfg.fov_down_angle;
         sum = fu + fd;
         if (x == 0 && y == 0) yaw = 0;
         else yaw = binary_angle(x * 256, y * 256);
         yaw = clip(yaw, -32768, 32768);
         if (rng == 0 && z == 0) pitch = 0;
         else pitch = binary_angle(isqrt_round(hsq << 16), z * 256);
         pitch = clip(pitch, -16384, 16384);
         col = (w * (yaw + 32768) + 32768) >>> 16;
         col = clip(col, 0, (w - 1 < 0) ? 0 : w - 1);
         col = clip(col, 0, MAX_WIDTH - 1);
         if (sum == 0) begin
            row = 0;
         end else begin
            num = h * (fu - pitch);
            if (num <= 0) row = 0;
            else row = (2 * num + sum) / (2 * sum);
         end
         row = clip(row, 0, (h - 1 < 0) ? 0 : h - 1);
         row = clip(row, 0, MAX_HEIGHT - 1);
         p.col = col[10:0];
         p.row = row[6:0];
         p.range_mm = rng[23:0];
         p.pitch = pitch[15:0];
         p.index = d[91:72];
         pending.push_back(p);
      endfunction

      function void check_pixel(logic [RSP_W-1:0] d);
         pixel_type e;
         if (pending.size() == 0) begin
            $error("unexpected pixel transfer %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[10:0] !== e.col) begin
            $error("pixel_col expected %0d actual %0d", e.col, d[10:0]); errors++;
         end
         if (d[17:11] !== e.row) begin
            $error("pixel_row expected %0d actual %0d", e.row, d[17:11]); errors++;
         end
         if (d[41:18] !== e.range_mm) begin
            $error("range_mm expected %0d actual %0d", e.range_mm, d[41:18]); errors++;
         end
         if (d[57:42] !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", $signed(e.pitch),
                   $signed(d[57:42]));
            errors++;
         end
         if (d[77:58] !== e.index) begin
            $error("index_out expected %0d actual %0d", e.index, d[77:58]); errors++;
         end
      endfunction
   endclass

   pixel_scoreboard sb;
   bit stim_done;

   task automatic csr_write(reg_index_type r, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (r)
         REG_WIDTH:    sb.cfg.col_count = v[11:0];
         REG_HEIGHT:   sb.cfg.row_count = v[7:0];
         REG_FOV_UP:   sb.cfg.fov_up_angle = v[14:0];
         REG_FOV_DOWN: sb.cfg.fov_down_angle = v[14:0];
      endcase
   endtask

   task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, 20'($urandom), z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_point(req_tdata);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (CORDIC_STAGES + 60) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return 24'($signed($urandom_range(0, 200)) - 100);
         3: return 24'($signed($urandom_range(0, 60000)) - 30000);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   initial begin
      sb = new();
      stim_done = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // defaults, directed corners
      send_point(24'd0, 24'd0, 24'd0);
      send_point(24'd0, 24'd0, 24'd500);
      send_point(24'd0, 24'd0, 24'hfffe0c);
      send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
      send_point(24'h800000, 24'h800000, 24'h800000);
      send_point(24'h800000, 24'd0, 24'd0);
      send_point(24'h800000, 24'hffffff, 24'd0);
      send_point(24'hffffff, 24'd0, 24'd1);
      send_point(24'd1000, 24'd0, 24'd0);
      send_point(24'd0, 24'd1000, 24'd0);
      send_point(24'd0, 24'hfffc18, 24'd0);
      send_point(24'd1, 24'd0, 24'h7fffff);
      send_point(24'd3, 24'd4, 24'hfffff4);
      random_phase(300);
      drain();
      csr_write(REG_WIDTH, 32'd2048);
      csr_write(REG_HEIGHT, 32'd128);
      csr_write(REG_FOV_UP, 32'd16384);
      csr_write(REG_FOV_DOWN, 32'd16384);
      random_phase(400);
      drain();
      csr_write(REG_WIDTH, 32'd1);
      csr_write(REG_HEIGHT, 32'd1);
      csr_write(REG_FOV_UP, 32'd0);
      csr_write(REG_FOV_DOWN, 32'd0);
      send_point(24'd5, 24'd5, 24'd5);
      random_phase(150);
      drain();
      // oversized and zero registers
      csr_write(REG_WIDTH, 32'hfff);
      csr_write(REG_HEIGHT, 32'hff);
      csr_write(REG_FOV_UP, 32'h7fff);
      csr_write(REG_FOV_DOWN, 32'd0);
      random_phase(200);
      drain();
      csr_write(REG_WIDTH, 32'd0);
      csr_write(REG_HEIGHT, 32'd0);
      csr_write(REG_FOV_UP, 32'd0);
      csr_write(REG_FOV_DOWN, 32'h7fff);
      random_phase(150);
      drain();
      for (int k = 0; k < 7; k++) begin
         csr_write(REG_WIDTH, $urandom_range(1, 2048));
         csr_write(REG_HEIGHT, $urandom_range(1, 128));
         csr_write(REG_FOV_UP, $urandom_range(0, 16384));
         csr_write(REG_FOV_DOWN, $urandom_range(0, 16384));
         random_phase(100);
         drain();
      end
      stim_done = 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata);
   end

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end
endmodule
